FILE: rtl/tbpf_pkg.sv
// Shared types and constants for the tile background pixel fetch block.
// Used by the pipeline, the top level and the bench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tbpf_pkg;

  // Transaction commands on the input channel
  typedef enum logic [1:0] {
    CMD_RENDER    = 2'd0,
    CMD_PATTERN   = 2'd1,
    CMD_NAMETABLE = 2'd2,
    CMD_PALETTE   = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam logic [1:0] REG_SCROLL_X    = 2'd0;
  localparam logic [1:0] REG_SCROLL_Y    = 2'd1;
  localparam logic [1:0] REG_PAT_SELECT  = 2'd2;

  // Store geometry
  localparam int PatternDepth   = 8192;
  localparam int NametableDepth = 2048;
  localparam int PaletteDepth   = 16;
  localparam int PatAddrW       = $clog2(PatternDepth);
  localparam int NtAddrW        = $clog2(NametableDepth);
  localparam int PalAddrW       = $clog2(PaletteDepth);

  // Upper bits of the attribute area address within a page (offset 960)
  localparam logic [3:0] ATTR_ROW_BITS = 4'b1111;

  // Live configuration handed to the pipeline
  typedef struct packed {
    logic [8:0] scroll_x;
    logic [7:0] scroll_y;
    logic       pat_select;
  } cfg_t;

  // Result of the last pipeline stage
  typedef struct packed {
    logic       valid;
    logic [7:0] color;
    logic       opaque;
  } result_t;

endpackage : tbpf_pkg

`default_nettype wire

FILE: rtl/tbpf_pipe.sv
// Four-stage fetch pipeline: scroll math, nametable, pattern and palette stages.
// Holds the three stores; depends on tbpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbpf_pipe (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [1:0]       cmd,
  input  wire logic [7:0]       column,
  input  wire logic [7:0]       line,
  input  wire logic [12:0]      address,
  input  wire logic [7:0]       data,
  input  wire tbpf_pkg::cfg_t   cfg,
  output tbpf_pkg::result_t     res
);
  import tbpf_pkg::*;

  // Stores; each is touched in exactly one stage so writes and reads stay in order
  logic [7:0] nt_mem  [NametableDepth];
  logic [7:0] pat_mem [PatternDepth];
  logic [7:0] pal_mem [PaletteDepth];

  // Stage 1 registers
  logic        s1_valid;
  cmd_t        s1_cmd;
  logic [12:0] s1_address;
  logic [7:0]  s1_data;
  logic        s1_page;
  logic [7:0]  s1_x;
  logic [7:0]  s1_y;

  // Stage 2 registers
  logic        s2_valid;
  cmd_t        s2_cmd;
  logic [12:0] s2_address;
  logic [7:0]  s2_data;
  logic [4:0]  s2_x;
  logic [4:0]  s2_y;
  logic [7:0]  s2_name;
  logic [7:0]  s2_attr;

  // Stage 3 registers
  logic        s3_valid;
  cmd_t        s3_cmd;
  logic [3:0]  s3_address;
  logic [7:0]  s3_data;
  logic [2:0]  s3_x;
  logic [1:0]  s3_high;
  logic [7:0]  s3_p0;
  logic [7:0]  s3_p1;

  // Stage 4 registers
  logic        s4_valid;
  logic        s4_opaque;
  logic [7:0]  s4_color;

  logic [8:0]          sx;
  logic [7:0]          sy;
  logic [NtAddrW-1:0]  name_addr;
  logic [NtAddrW-1:0]  attr_addr;
  logic [PatAddrW-1:0] p0_addr;
  logic [PatAddrW-1:0] p1_addr;
  logic [1:0]          attr_sel;
  logic [1:0]          high;
  logic [1:0]          low;
  logic [PalAddrW-1:0] pal_index;

  // Stage 0: scrolled coordinates (bit 8 of sx is the page, carry out dropped)
  assign sx = cfg.scroll_x + {1'b0, column};
  assign sy = cfg.scroll_y + line;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd     <= cmd_t'(cmd);
      s1_address <= address;
      s1_data    <= data;
      s1_page    <= sx[8];
      s1_x       <= sx[7:0];
      s1_y       <= sy;
    end
  end

  // Stage 1: nametable write, or name and attribute reads
  assign name_addr = {s1_page, s1_y[7:3], s1_x[7:3]};
  assign attr_addr = {s1_page, ATTR_ROW_BITS, s1_y[7:5], s1_x[7:5]};

  always_ff @(posedge clk) begin
    if (en) begin
      if (s1_valid && s1_cmd == CMD_NAMETABLE) begin
        nt_mem[s1_address[NtAddrW-1:0]] <= s1_data;
      end
      s2_name <= nt_mem[name_addr];
      s2_attr <= nt_mem[attr_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_cmd     <= s1_cmd;
      s2_address <= s1_address;
      s2_data    <= s1_data;
      s2_x       <= s1_x[4:0];
      s2_y       <= s1_y[4:0];
    end
  end

  // Stage 2: pattern write, or both bit plane reads; attribute quadrant select
  assign p0_addr  = {cfg.pat_select, s2_name, 1'b0, s2_y[2:0]};
  assign p1_addr  = {cfg.pat_select, s2_name, 1'b1, s2_y[2:0]};
  assign attr_sel = {s2_y[4], s2_x[4]};
  assign high     = s2_attr[{attr_sel, 1'b0} +: 2];

  always_ff @(posedge clk) begin
    if (en) begin
      if (s2_valid && s2_cmd == CMD_PATTERN) begin
        pat_mem[s2_address] <= s2_data;
      end
      s3_p0 <= pat_mem[p0_addr];
      s3_p1 <= pat_mem[p1_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_cmd     <= s2_cmd;
      s3_address <= s2_address[PalAddrW-1:0];
      s3_data    <= s2_data;
      s3_x       <= s2_x[2:0];
      s3_high    <= high;
    end
  end

  // Stage 3: pixel bits, palette write or lookup (transparent uses entry 0)
  assign low       = {s3_p1[~s3_x], s3_p0[~s3_x]};
  assign pal_index = (low == 2'b00) ? '0 : {s3_high, low};

  always_ff @(posedge clk) begin
    if (en) begin
      if (s3_valid && s3_cmd == CMD_PALETTE) begin
        pal_mem[s3_address] <= s3_data;
      end
      s4_color  <= pal_mem[pal_index];
      s4_opaque <= (low != 2'b00);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid && s3_cmd == CMD_RENDER;
    end
  end

  always_comb begin
    res.valid  = s4_valid;
    res.color  = s4_color;
    res.opaque = s4_opaque;
  end

endmodule : tbpf_pipe

`default_nettype wire

FILE: rtl/tile_background_pixel_fetch.sv
// A render transaction passes stage registers s1 to s4, then the out_valid register.
// Throughput: one transaction (render or store write) per cycle; the pipeline only
// pauses when its result skid register is full, which asserts in_stall.
// Reset (rst, synchronous) clears all valid bits and the scroll/select registers;
// pattern, nametable and palette stores are undefined until written.
// Top level: configuration registers, fetch pipeline and output skid register.
// Depends on tbpf_pkg and tbpf_pipe.
`timescale 1ns / 1ps
`default_nettype none

module tile_background_pixel_fetch (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  column,
  input  wire logic [7:0]  line,
  input  wire logic [12:0] address,
  input  wire logic [7:0]  data,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       color,
  output logic             opaque,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);
  import tbpf_pkg::*;

  cfg_t       cfg;
  result_t    res;
  logic       en;
  logic       skid_valid;
  logic [7:0] skid_color;
  logic       skid_opaque;

  assign cfg_ready = 1'b1;

  // Configuration registers; indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCROLL_X:   cfg.scroll_x   <= cfg_data;
        REG_SCROLL_Y:   cfg.scroll_y   <= cfg_data[7:0];
        REG_PAT_SELECT: cfg.pat_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline advances unless a result is parked in the skid register
  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  tbpf_pipe u_pipe (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .cmd      (cmd),
    .column   (column),
    .line     (line),
    .address  (address),
    .data     (data),
    .cfg      (cfg),
    .res      (res)
  );

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid  <= skid_valid || (en && res.valid);
      skid_valid <= 1'b0;
    end else if (en && res.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        color  <= skid_color;
        opaque <= skid_opaque;
      end else begin
        color  <= res.color;
        opaque <= res.opaque;
      end
    end else if (en && res.valid) begin
      skid_color  <= res.color;
      skid_opaque <= res.opaque;
    end
  end

endmodule : tile_background_pixel_fetch

`default_nettype wire

FILE: rtl/tbpf_checker.sv
// Port-level checks for tile_background_pixel_fetch, attached with bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module tbpf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] color,
  input wire logic       opaque
);

  // Nothing leaves the block the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(color) && $stable(opaque))
    else $error("stalled result changed");

  // Input back-pressure only while a result waits downstream
  a_stall_pending: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("in_stall without a pending result");

  // Back-pressure starts only after the output was stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("in_stall rose without an output stall");

  // Draining the output frees the input the next cycle
  a_stall_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !in_stall)
    else $error("in_stall held after output drained");

endmodule : tbpf_checker

bind tile_background_pixel_fetch tbpf_checker u_tbpf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .color     (color),
  .opaque    (opaque)
);

`default_nettype wire

FILE: bench/tbpf_pixel_checker.sv
`timescale 1ns / 1ps
// Pixel checker for tile_background_pixel_fetch: mirrors the three stores and the
// scroll registers, predicts every rendered pixel and compares it on the output side.
// Depends on tbpf_pkg.

module tbpf_pixel_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  column,
  input  logic [7:0]  line,
  input  logic [12:0] address,
  input  logic [7:0]  data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  color,
  input  logic        opaque,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  output int          pending,
  output int          faults
);
  import tbpf_pkg::*;

  typedef struct packed {
    logic [7:0] color;
    logic       opaque;
  } pixel_t;

  // Local copies of the stores and registers
  logic [7:0] pattern_mem [0:PatternDepth-1];
  logic [7:0] name_mem    [0:NametableDepth-1];
  logic [7:0] palette_mem [0:PaletteDepth-1];
  logic [8:0] scroll_x_q = '0;
  logic [7:0] scroll_y_q = '0;
  logic       pat_sel_q  = 1'b0;

  pixel_t pixels_due [$];
  int     fault_count = 0;

  assign faults = fault_count;

  // Background pixel at a screen position under the current scroll and pattern half
  function automatic pixel_t shade_pixel(input logic [7:0] col, input logic [7:0] ln);
    logic [9:0]  sx;
    logic [7:0]  x, y;
    logic [10:0] name_at, attr_at;
    logic [12:0] row_at;
    logic [7:0]  plane0, plane1, attr;
    logic [2:0]  bitpos;
    logic [1:0]  low, high;
    pixel_t      px;
    sx = {1'b0, scroll_x_q} + {2'b00, col};
    x  = sx[7:0];
    y  = scroll_y_q + ln;
    // bit 8 of the scrolled x picks the page; bit 9 falls off
    name_at = {sx[8], y[7:3], x[7:3]};
    attr_at = {sx[8], ATTR_ROW_BITS, y[7:5], x[7:5]};
    row_at  = {pat_sel_q, name_mem[name_at], 1'b0, y[2:0]};
    plane0  = pattern_mem[row_at];
    plane1  = pattern_mem[row_at | 13'd8];
    bitpos  = 3'd7 - x[2:0];
    low     = {plane1[bitpos], plane0[bitpos]};
    attr    = name_mem[attr_at];
    high    = attr[{y[4], x[4], 1'b0} +: 2];
    // transparent pixels share the backdrop entry
    px.color  = palette_mem[(low == 2'd0) ? 4'd0 : {high, low}];
    px.opaque = (low != 2'd0);
    return px;
  endfunction

  task automatic flag(input string what, input pixel_t want, input pixel_t got);
    fault_count++;
    if (fault_count <= 10)
      $display("%0t: %s: color exp %h got %h, opaque exp %b got %b",
               $realtime, what, want.color, got.color, want.opaque, got.opaque);
  endtask

  always @(posedge clk) begin : watch
    pixel_t got;
    pixel_t want;
    got.color  = color;
    got.opaque = opaque;
    if (rst) begin
      scroll_x_q = '0;
      scroll_y_q = '0;
      pat_sel_q  = 1'b0;
      pixels_due.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCROLL_X:   scroll_x_q = cfg_data;
          REG_SCROLL_Y:   scroll_y_q = cfg_data[7:0];
          REG_PAT_SELECT: pat_sel_q  = cfg_data[0];
          default: ;
        endcase
      end
      // result transactions against the oldest prediction
      if (out_valid && !out_stall) begin
        if (pixels_due.size() == 0) begin
          flag("unexpected pixel", '0, got);
        end else begin
          want = pixels_due.pop_front();
          if (got.color !== want.color || got.opaque !== want.opaque)
            flag("pixel mismatch", want, got);
        end
      end
      // input transactions: store writes or a render
      if (in_valid && !in_stall) begin
        case (cmd)
          CMD_RENDER:    pixels_due.push_back(shade_pixel(column, line));
          CMD_PATTERN:   pattern_mem[address] = data;
          CMD_NAMETABLE: name_mem[address[NtAddrW-1:0]] = data;
          CMD_PALETTE:   palette_mem[address[PalAddrW-1:0]] = data;
          default: ;
        endcase
      end
    end
    pending <= pixels_due.size();
  end

endmodule

FILE: bench/tb_tile_background_pixel_fetch.sv
`timescale 1ns / 1ps
// Testbench top for tile_background_pixel_fetch: drives store writes, renders and
// register writes under several idle/stall mixes and gives the verdict.
// Depends on tbpf_pkg, the block under rtl/ and tbpf_pixel_checker.

module tb_tile_background_pixel_fetch;
  import tbpf_pkg::*;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd       = CMD_RENDER;
  logic [7:0]  column    = '0;
  logic [7:0]  line      = '0;
  logic [12:0] address   = '0;
  logic [7:0]  data      = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  color;
  logic        opaque;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_SCROLL_X;
  logic [8:0]  cfg_data  = '0;
  int          pending;
  int          faults;

  // Idle mix and hold-off control
  int   gap_pct    = 0;
  int   stall_pct  = 0;
  logic hold_go    = 1'b0;
  int   hold_left  = 0;
  int   sent_items = 0;

  // What the stimulus has set up so far; renders only touch written entries
  logic [8:0] cur_sx  = '0;
  logic [7:0] cur_sy  = '0;
  logic       cur_sel = 1'b0;
  bit         pat_done  [0:PatternDepth-1];
  bit         nt_done   [0:NametableDepth-1];
  logic [7:0] nt_shadow [0:NametableDepth-1];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tile_background_pixel_fetch dut (
    .clk, .rst,
    .in_valid, .in_stall, .cmd, .column, .line, .address, .data,
    .out_valid, .out_stall, .color, .opaque,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  tbpf_pixel_checker u_checker (.*);

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left <= 60;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  // One input transaction; valid stays high for the next one unless a gap follows
  task automatic send(input logic [1:0] op, input logic [7:0] col, input logic [7:0] ln,
                      input logic [12:0] a, input logic [7:0] d);
    while (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    case (op)
      CMD_PATTERN:   pat_done[a] = 1'b1;
      CMD_NAMETABLE: begin
        nt_done[a[NtAddrW-1:0]]   = 1'b1;
        nt_shadow[a[NtAddrW-1:0]] = d;
      end
      default: ;
    endcase
    in_valid <= 1'b1;
    cmd      <= op;
    column   <= col;
    line     <= ln;
    address  <= a;
    data     <= d;
    do @(posedge clk); while (in_stall);
    sent_items++;
  endtask

  task automatic write_store(input logic [1:0] op, input logic [12:0] a, input logic [7:0] d);
    send(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), a, d);
  endtask

  // Render a pixel, first filling any store entry it would read that is still unwritten
  task automatic render(input logic [7:0] col, input logic [7:0] ln);
    logic [9:0]  sx;
    logic [7:0]  x, y;
    logic [10:0] name_at, attr_at;
    logic [12:0] a;
    sx = {1'b0, cur_sx} + {2'b00, col};
    x  = sx[7:0];
    y  = cur_sy + ln;
    name_at = {sx[8], y[7:3], x[7:3]};
    attr_at = {sx[8], ATTR_ROW_BITS, y[7:5], x[7:5]};
    // nametable writes carry random bits above the page bit
    if (!nt_done[name_at]) begin
      a = 13'($urandom_range(0, 8191));
      a[NtAddrW-1:0] = name_at;
      write_store(CMD_NAMETABLE, a, 8'($urandom_range(0, 255)));
    end
    if (!nt_done[attr_at]) begin
      a = 13'($urandom_range(0, 8191));
      a[NtAddrW-1:0] = attr_at;
      write_store(CMD_NAMETABLE, a, 8'($urandom_range(0, 255)));
    end
    a = {cur_sel, nt_shadow[name_at], 1'b0, y[2:0]};
    if (!pat_done[a]) write_store(CMD_PATTERN, a, 8'($urandom_range(0, 255)));
    a = a | 13'd8;
    if (!pat_done[a]) write_store(CMD_PATTERN, a, 8'($urandom_range(0, 255)));
    send(CMD_RENDER, col, ln, 13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)));
  endtask

  // Wait until every pixel is out and the pipeline has flushed its writes
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_regs(input logic [8:0] sx, input logic [7:0] sy, input logic sel);
    put_reg(REG_SCROLL_X, sx);
    put_reg(REG_SCROLL_Y, {1'b0, sy});
    put_reg(REG_PAT_SELECT, {8'd0, sel});
    cfg_valid <= 1'b0;
    cur_sx  = sx;
    cur_sy  = sy;
    cur_sel = sel;
  endtask

  // One phase: new settings, optional back-pressure burst, then random traffic
  task automatic run_phase(input logic [8:0] sx, input logic [7:0] sy, input logic sel,
                           input int gap, input int stall, input int count, input bit squeeze);
    int         stop_at;
    int         roll;
    int         run_len;
    logic [7:0] col, ln;
    settle();
    load_regs(sx, sy, sel);
    gap_pct   = gap;
    stall_pct = stall;
    stop_at   = sent_items + count;
    if (squeeze) begin
      // receiver holds off while a scanline streams in back to back
      hold_go <= 1'b1;
      @(posedge clk);
      hold_go <= 1'b0;
      col = 8'($urandom_range(0, 255));
      ln  = 8'($urandom_range(0, 239));
      for (int i = 0; i < 40; i++) render(8'(col + i), ln);
    end
    while (sent_items < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        // a run of neighboring pixels on one line, sometimes past the visible rows
        ln = 8'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 239)
                                             : $urandom_range(240, 255));
        col = 8'($urandom_range(0, 255));
        run_len = $urandom_range(1, 12);
        for (int i = 0; i < run_len; i++) render(8'(col + i), ln);
      end else if (roll < 90) begin
        write_store(2'($urandom_range(int'(CMD_PATTERN), int'(CMD_PALETTE))),
                    13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)));
      end else begin
        render(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Palette first, with junk above the low four address bits
    for (int i = 0; i < PaletteDepth; i++)
      write_store(CMD_PALETTE, 13'(($urandom_range(0, 511) << 4) | i),
                  (i == 0) ? 8'h00 : (i == PaletteDepth - 1) ? 8'hFF
                                                               : 8'($urandom_range(0, 255)));
    // Store address extremes; nametable bits above the page are ignored
    write_store(CMD_PATTERN, 13'h1FFF, 8'hFF);
    write_store(CMD_PATTERN, 13'h0000, 8'h00);
    write_store(CMD_NAMETABLE, 13'h1FFF, 8'hA5);

    // Reset settings: corners, last visible line, lines past the visible area
    render(8'd0, 8'd0);
    render(8'd255, 8'd239);
    render(8'd255, 8'd255);
    render(8'd7, 8'd8);
    render(8'd128, 8'd240);

    // Full scroll and upper pattern half: page wrap and scrolled x past 511
    settle();
    load_regs(9'd511, 8'd255, 1'b1);
    render(8'd0, 8'd0);
    render(8'd1, 8'd0);
    render(8'd255, 8'd239);
    render(8'd16, 8'd17);

    run_phase(9'd0,   8'd0,   1'b0, 0,  0,  178, 1'b0);
    run_phase(9'd511, 8'd255, 1'b1, 71, 0,  178, 1'b0);
    run_phase(9'd256, 8'd16,  1'b0, 0,  71, 178, 1'b0);
    run_phase(9'd255, 8'd239, 1'b1, 37, 37, 178, 1'b0);
    run_phase(9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), 0, 0, 178, 1'b1);
    run_phase(9'd1,   8'd1,   1'b0, 71, 0,  178, 1'b0);
    run_phase(9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), 0, 71, 178, 1'b0);
    run_phase(9'd0,   8'd255, 1'b0, 37, 37, 178, 1'b0);

    settle();
    if (faults == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
